>>> rtl/core/dqsr_pkg.sv
package dqsr_pkg;
  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CONTAINS   = 3'd4,
    OP_REMOVE     = 3'd5
  } op_e;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StEmpty    = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic        load;
    logic        push_front;
    logic        push_back;
    logic        pop_front;
    logic        pop_back;
    logic        remove;
  } dqsr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic hit;
  } dqsr_stat_t;
endpackage

>>> rtl/core/dqsr_datapath.sv
module dqsr_datapath import dqsr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dqsr_cmd_t          cmd_i,
  input  logic [31:0]        value_i,
  output dqsr_stat_t         stat_o,
  output logic [31:0]        front_o,
  output logic [31:0]        back_o,
  output logic [CntW-1:0]    count_o
);
  logic [31:0]     cells_q [Depth];
  logic [31:0]     cells_d [Depth];
  logic [CntW-1:0] count_q, count_d;
  logic [Depth-1:0] match, first;

  // one comparator per cell, masked by occupancy
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      match[i] = (CntW'(i) < count_q) && (cells_q[i] == value_i);
    end
    first = match & ~(match - Depth'(1));
  end

  assign stat_o.full  = count_q == CntW'(Depth);
  assign stat_o.empty = count_q == '0;
  assign stat_o.hit   = |match;

  always_comb begin
    logic [Depth-1:0] shl;
    shl = first | ~(first - Depth'(1)) ;
    cells_d = cells_q;
    count_d = count_q;
    if (cmd_i.push_front) begin
      for (int i = 1; i < Depth; i++) cells_d[i] = cells_q[i-1];
      cells_d[0] = value_i;
      count_d = count_q + CntW'(1);
    end else if (cmd_i.push_back) begin
      cells_d[count_q[IdxW-1:0]] = value_i;
      count_d = count_q + CntW'(1);
    end else if (cmd_i.pop_front) begin
      for (int i = 0; i < Depth - 1; i++) cells_d[i] = cells_q[i+1];
      count_d = count_q - CntW'(1);
    end else if (cmd_i.pop_back) begin
      count_d = count_q - CntW'(1);
    end else if (cmd_i.remove) begin
      // cells at or above the hit take their upper neighbor
      for (int i = 0; i < Depth - 1; i++) begin
        if (shl[i]) cells_d[i] = cells_q[i+1];
      end
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) cells_q <= cells_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load) begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;
  assign front_o = (count_q == '0) ? '0 : cells_q[0];
  assign back_o  = (count_q == '0) ? '0 : cells_q[IdxW'(count_q - CntW'(1))];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("count overflow");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.load |=> $stable(count_q)) else $error("count moved");
  a_first_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(first)) else $error("first match not unique");
endmodule

>>> rtl/core/dqsr_ctrl.sv
module dqsr_ctrl import dqsr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  dqsr_stat_t  stat_i,
  output dqsr_cmd_t   cmd_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        found_o
);
  typedef enum logic {S_IDLE, S_SHOW} state_e;
  state_e state_q;
  logic [1:0] status_q, status_d;
  logic found_q, found_d;
  logic take;

  // the output register frees as it is read, so a word may enter meanwhile
  assign in_ready_o = (state_q == S_IDLE) || out_ready_i;
  assign take = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = '0;
    status_d = StOk;
    found_d = 1'b0;
    cmd_o.load = take;
    case (opcode_i)
      OP_PUSH_FRONT: if (stat_i.full) status_d = StFull; else cmd_o.push_front = take;
      OP_PUSH_BACK:  if (stat_i.full) status_d = StFull; else cmd_o.push_back = take;
      OP_POP_FRONT:  if (stat_i.empty) status_d = StEmpty; else cmd_o.pop_front = take;
      OP_POP_BACK:   if (stat_i.empty) status_d = StEmpty; else cmd_o.pop_back = take;
      OP_CONTAINS: begin
        found_d = stat_i.hit;
        if (!stat_i.hit) status_d = StNotFound;
      end
      OP_REMOVE: begin
        found_d = stat_i.hit;
        if (!stat_i.hit) status_d = StNotFound; else cmd_o.remove = take;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      status_q <= StOk;
      found_q <= 1'b0;
    end else if (take) begin
      state_q <= S_SHOW;
      status_q <= status_d;
      found_q <= found_d;
    end else if (out_ready_i) begin
      state_q <= S_IDLE;
    end
  end

  assign out_valid_o = state_q == S_SHOW;
  assign status_o = status_q;
  assign found_o = found_q;

  a_take_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_o) else $error("result missing");
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == StOk) else $error("found with bad status");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(status_o)) else $error("result moved");
endmodule

>>> rtl/core/deque_with_search_remove.sv
// Deque of 16 signed 32-bit words with search and remove-first.
// Input stream: s_axis_tdata = {operand_value, opcode} (opcode in the
// low 3 bits), one word per operation. Opcodes: push front/back, pop
// front/back, contains, remove first match.
// Output stream: one word per operation with status, found, the front
// and back entries, count and empty flag after the operation.
// The result is registered as the input word is taken and shows in the
// next cycle. Throughput is one word per cycle unless the receiver stalls;
// all 16 cells compare and shift in parallel, so search and remove keep pace.
// When the receiver stalls, the result holds and s_axis_tready drops
// until it is taken; a new word may enter in the cycle it is read.
// Reset empties the queue; cell contents are not cleared and are never
// shown before being written.
module deque_with_search_remove import dqsr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // opcode[2:0], operand_value[34:3], zero
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata   // status[1:0], found[2], front_value[34:3],
                                      // back_value[66:35], entry_count[71:67],
                                      // is_empty[72], zero
);
  dqsr_cmd_t  cmd;
  dqsr_stat_t stat;
  logic [1:0] status;
  logic found;
  logic [31:0] front, back;
  logic [CntW-1:0] count;

  dqsr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .opcode_i(s_axis_tdata[2:0]),
    .stat_i(stat), .cmd_o(cmd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .status_o(status), .found_o(found)
  );

  dqsr_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .value_i(s_axis_tdata[34:3]),
    .stat_o(stat), .front_o(front), .back_o(back), .count_o(count)
  );

  assign m_axis_tdata = {7'd0, (count == '0), 5'(count), back, front, found, status};
endmodule
